/* rtl/nddi_pkg.sv */
// Shared types and constants of the Newton divided-difference interpolator.
// Transaction payload structs, command codes and status codes.
// No dependencies.
package nddi_pkg;

  // Command codes of an input transaction.
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  // Status codes of a result transaction.
  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NOT_READY = 2'd1;
  localparam logic [1:0] STAT_DUPLICATE = 2'd2;
  localparam logic [1:0] STAT_SATURATED = 2'd3;

  // Width of the node count register.
  localparam int unsigned NodeCountW = 5;

  // Input transaction payload.
  typedef struct packed {
    logic               command;
    logic signed [31:0] node_x;
    logic signed [31:0] node_y;
    logic signed [31:0] query_x;
  } in_t;

  // Result transaction payload.
  typedef struct packed {
    logic signed [31:0] value;
    logic [1:0]         status;
  } out_t;

endpackage

/* rtl/nddi_ram.sv */
// Synchronous single-port-write, single-port-read memory of 32-bit words.
// Read data is registered. Uses no package.
module nddi_ram #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [31:0]              wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [31:0]              rdata_o
);

  logic [31:0] mem [DEPTH];
  logic [31:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/nddi_div.sv */
// Bit-serial restoring divider: floor(num * 2^FRAC_BITS / den), saturated to 32 bits.
// One quotient bit per cycle. Uses no package.
module nddi_div #(
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [32:0] num_i,
  input  logic signed [32:0] den_i,
  output logic               done_o,
  output logic [31:0]        quot_o,
  output logic               sat_o
);

  localparam int unsigned NW   = 33 + FRAC_BITS;
  localparam int unsigned CNTW = $clog2(NW + 1);

  typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIN} dstate_e;

  dstate_e         state_q;
  logic [CNTW-1:0] cnt_q;
  logic [NW-1:0]   dq_q;
  logic [32:0]     dm_q;
  logic [33:0]     rem_q;
  logic            neg_q;
  logic            done_q;
  logic [31:0]     quot_q;
  logic            sat_q;

  logic [32:0]     num_mag;
  logic [32:0]     den_mag;
  logic [33:0]     trial;
  logic            fits;
  logic signed [NW:0] sq;
  logic            ovf;

  // Magnitudes of the operands.
  assign num_mag = num_i[32] ? 33'(-num_i) : 33'(num_i);
  assign den_mag = den_i[32] ? 33'(-den_i) : 33'(den_i);

  // One restoring step.
  assign trial = {rem_q[32:0], dq_q[NW-1]};
  assign fits  = trial >= {1'b0, dm_q};

  // Signed floor quotient and its range check.
  always_comb begin
    if (neg_q) begin
      sq = -$signed({1'b0, dq_q}) - $signed((NW+1)'(rem_q != '0));
    end else begin
      sq = $signed({1'b0, dq_q});
    end
    ovf = !((&sq[NW:31]) || !(|sq[NW:31]));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        D_IDLE: begin
          if (start_i) begin
            neg_q   <= num_i[32] ^ den_i[32];
            dq_q    <= {num_mag, {FRAC_BITS{1'b0}}};
            dm_q    <= den_mag;
            rem_q   <= '0;
            cnt_q   <= CNTW'(NW);
            state_q <= D_RUN;
          end
        end
        D_RUN: begin
          rem_q <= fits ? (trial - {1'b0, dm_q}) : trial;
          dq_q  <= {dq_q[NW-2:0], fits};
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == CNTW'(1)) begin
            state_q <= D_FIN;
          end
        end
        D_FIN: begin
          if (ovf) begin
            quot_q <= sq[NW] ? 32'h8000_0000 : 32'h7fff_ffff;
          end else begin
            quot_q <= sq[31:0];
          end
          sat_q   <= ovf;
          done_q  <= 1'b1;
          state_q <= D_IDLE;
        end
        default: state_q <= D_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign sat_o  = sat_q;

endmodule

/* rtl/nddi_mul.sv */
// Bit-serial signed multiplier, 32 by 33 bits, giving a 65-bit product.
// One bit of the second operand per cycle. Uses no package.
module nddi_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [31:0] a_i,
  input  logic signed [32:0] b_i,
  output logic               done_o,
  output logic signed [64:0] prod_o
);

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} mstate_e;

  mstate_e            state_q;
  logic [5:0]         cnt_q;
  logic [31:0]        ma_q;
  logic [32:0]        mb_q;
  logic [63:0]        acc_q;
  logic               neg_q;
  logic               done_q;
  logic signed [64:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= M_IDLE;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        M_IDLE: begin
          if (start_i) begin
            neg_q   <= a_i[31] ^ b_i[32];
            ma_q    <= a_i[31] ? 32'(-a_i) : 32'(a_i);
            mb_q    <= b_i[32] ? 33'(-b_i) : 33'(b_i);
            acc_q   <= '0;
            cnt_q   <= 6'd33;
            state_q <= M_RUN;
          end
        end
        M_RUN: begin
          // Shift-and-add, most significant bit first.
          acc_q <= {acc_q[62:0], 1'b0} + (mb_q[32] ? {32'd0, ma_q} : 64'd0);
          mb_q  <= {mb_q[31:0], 1'b0};
          cnt_q <= cnt_q - 1'b1;
          if (cnt_q == 6'd1) begin
            state_q <= M_FIN;
          end
        end
        M_FIN: begin
          prod_q  <= neg_q ? -$signed({1'b0, acc_q}) : $signed({1'b0, acc_q});
          done_q  <= 1'b1;
          state_q <= M_IDLE;
        end
        default: state_q <= M_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

/* rtl/newton_divided_difference_interp.sv */
// Top level of the Newton divided-difference interpolator.
// Depends on nddi_pkg, nddi_ram, nddi_div and nddi_mul.
//
//   Port group   Direction  Handshake                Payload
//   in_*         input      in_valid_i/in_stall_o    nddi_pkg::in_t
//   out_*        output     out_valid_o/out_stall_i  nddi_pkg::out_t
//   cfg_*        input      cfg_we_i                 node_count (5 bits)
//
// Completing a set of n nodes runs n(n-1)/2 serial divisions in the divider. An
// evaluate on n nodes runs one bit-serial multiplication per node after the first.
// The result register lets the next transaction in while a result waits. Reset is
// asynchronous, active low; the node stores need no clearing. out_stall_i holds the
// finished result and, while that register is full, the sequencer in S_DONE.
module newton_divided_difference_interp #(
  parameter int unsigned MAX_NODES = 16,
  parameter int unsigned FRAC_BITS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  nddi_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output nddi_pkg::out_t                      out_data_o,
  input  logic                                cfg_we_i,
  input  logic [nddi_pkg::NodeCountW-1:0]     cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_NODES);
  localparam int unsigned CW = $clog2(MAX_NODES + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_B_RD0, S_B_RD1, S_B_RD2, S_B_DIV,
    S_E_INIT, S_E_STEP, S_E_CAP, S_E_MUL, S_DONE
  } state_e;

  state_e                         state_q;
  logic [nddi_pkg::NodeCountW-1:0] node_count_q;
  logic [CW-1:0]                  cnt_q;
  logic                           ready_q;
  logic                           faulty_q;
  logic [AW-1:0]                  k_q;
  logic [AW-1:0]                  i_q;
  logic signed [31:0]             q_q;
  logic signed [31:0]             r_q;
  logic signed [31:0]             c_i_q;
  logic signed [31:0]             x_i_q;
  logic                           sat_q;
  nddi_pkg::out_t                 pend_q;
  logic                           out_valid_q;
  nddi_pkg::out_t                 out_data_q;

  logic                           accept;
  logic                           is_load;
  logic                           out_free;
  logic [CW-1:0]                  eff;
  logic                           new_set;
  logic [CW-1:0]                  idx;
  logic [CW-1:0]                  cnt_next;
  logic [AW-1:0]                  last_idx;

  logic                           c_we;
  logic [AW-1:0]                  c_waddr;
  logic [31:0]                    c_wdata;
  logic [AW-1:0]                  c_raddr;
  logic [AW-1:0]                  x_raddr;
  logic [31:0]                    c_rdata;
  logic [31:0]                    x_rdata;

  logic signed [32:0]             num_w;
  logic signed [32:0]             den_w;
  logic                           div_start;
  logic                           div_done;
  logic [31:0]                    div_quot;
  logic                           div_sat;

  logic signed [32:0]             diff_w;
  logic                           mul_start;
  logic                           mul_done;
  logic signed [64:0]             mul_prod;
  logic signed [64:0]             shifted;
  logic signed [65:0]             sum_w;
  logic                           sum_ovf;
  logic signed [31:0]             sum_sat;

  // Input transaction and set bookkeeping for a load.
  assign in_stall_o = state_q != S_IDLE;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_load    = in_data_i.command == nddi_pkg::CMD_LOAD;
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    if (node_count_q == '0) begin
      eff = CW'(1);
    end else if (32'(node_count_q) > MAX_NODES) begin
      eff = CW'(MAX_NODES);
    end else begin
      eff = CW'(node_count_q);
    end
  end

  assign new_set  = ready_q || (cnt_q >= eff);
  assign idx      = new_set ? '0 : cnt_q;
  assign cnt_next = idx + 1'b1;
  assign last_idx = AW'(cnt_q - 1'b1);

  // Memory port control.
  always_comb begin
    c_we    = 1'b0;
    c_waddr = AW'(idx);
    c_wdata = in_data_i.node_y;
    if (accept && is_load) begin
      c_we = 1'b1;
    end else if (state_q == S_B_DIV && div_done) begin
      c_we    = 1'b1;
      c_waddr = i_q;
      c_wdata = div_quot;
    end
  end

  always_comb begin
    c_raddr = i_q;
    x_raddr = i_q;
    case (state_q)
      S_IDLE: begin
        c_raddr = last_idx;
      end
      S_E_STEP: begin
        c_raddr = i_q - 1'b1;
        x_raddr = i_q - 1'b1;
      end
      S_B_RD1: begin
        c_raddr = i_q - 1'b1;
        x_raddr = i_q - k_q;
      end
      default: begin
        c_raddr = i_q;
        x_raddr = i_q;
      end
    endcase
  end

  nddi_ram #(.DEPTH(MAX_NODES)) u_x_ram (
    .clk_i   (clk_i),
    .we_i    (accept && is_load),
    .waddr_i (AW'(idx)),
    .wdata_i (in_data_i.node_x),
    .raddr_i (x_raddr),
    .rdata_o (x_rdata)
  );

  nddi_ram #(.DEPTH(MAX_NODES)) u_c_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (c_waddr),
    .wdata_i (c_wdata),
    .raddr_i (c_raddr),
    .rdata_o (c_rdata)
  );

  // Divided difference operands.
  assign num_w     = 33'(c_i_q) - 33'($signed(c_rdata));
  assign den_w     = 33'(x_i_q) - 33'($signed(x_rdata));
  assign div_start = state_q == S_B_RD2 && den_w != '0;

  nddi_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num_w),
    .den_i   (den_w),
    .done_o  (div_done),
    .quot_o  (div_quot),
    .sat_o   (div_sat)
  );

  // Nested evaluation step.
  assign diff_w    = 33'(q_q) - 33'($signed(x_rdata));
  assign mul_start = state_q == S_E_CAP;

  nddi_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (r_q),
    .b_i     (diff_w),
    .done_o  (mul_done),
    .prod_o  (mul_prod)
  );

  assign shifted = mul_prod >>> FRAC_BITS;
  assign sum_w   = 66'(shifted) + 66'(c_i_q);
  assign sum_ovf = !((&sum_w[65:31]) || !(|sum_w[65:31]));
  assign sum_sat = sum_ovf ? (sum_w[65] ? 32'sh8000_0000 : 32'sh7fff_ffff) : sum_w[31:0];

  // Sequencer, set state and result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      node_count_q <= nddi_pkg::NodeCountW'(3);
      cnt_q        <= '0;
      ready_q      <= 1'b0;
      faulty_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        node_count_q <= cfg_data_i;
      end
      if (out_free) begin
        out_valid_q <= state_q == S_DONE;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            pend_q.value <= '0;
            sat_q        <= 1'b0;
            if (is_load) begin
              cnt_q         <= cnt_next;
              pend_q.status <= nddi_pkg::STAT_OK;
              k_q           <= AW'(1);
              i_q           <= AW'(cnt_next - 1'b1);
              // A load either continues an incomplete set or starts a new one.
              ready_q       <= cnt_next == eff;
              faulty_q      <= 1'b0;
              if (cnt_next == eff) begin
                state_q <= (cnt_next == CW'(1)) ? S_DONE : S_B_RD0;
              end else begin
                state_q <= S_DONE;
              end
            end else if (!ready_q) begin
              pend_q.status <= nddi_pkg::STAT_NOT_READY;
              state_q       <= S_DONE;
            end else if (faulty_q) begin
              pend_q.status <= nddi_pkg::STAT_DUPLICATE;
              state_q       <= S_DONE;
            end else begin
              q_q     <= in_data_i.query_x;
              state_q <= S_E_INIT;
            end
          end
        end
        S_B_RD0: begin
          state_q <= S_B_RD1;
        end
        S_B_RD1: begin
          c_i_q   <= c_rdata;
          x_i_q   <= x_rdata;
          state_q <= S_B_RD2;
        end
        S_B_RD2: begin
          if (den_w == '0) begin
            faulty_q      <= 1'b1;
            pend_q.status <= nddi_pkg::STAT_DUPLICATE;
            state_q       <= S_DONE;
          end else begin
            state_q <= S_B_DIV;
          end
        end
        S_B_DIV: begin
          if (div_done) begin
            sat_q <= sat_q || div_sat;
            if (i_q == k_q) begin
              if (k_q == last_idx) begin
                pend_q.status <= (sat_q || div_sat) ? nddi_pkg::STAT_SATURATED
                                                    : nddi_pkg::STAT_OK;
                state_q <= S_DONE;
              end else begin
                k_q     <= k_q + 1'b1;
                i_q     <= last_idx;
                state_q <= S_B_RD0;
              end
            end else begin
              i_q     <= i_q - 1'b1;
              state_q <= S_B_RD0;
            end
          end
        end
        S_E_INIT: begin
          r_q     <= c_rdata;
          i_q     <= last_idx;
          state_q <= S_E_STEP;
        end
        S_E_STEP: begin
          if (i_q == '0) begin
            pend_q.value  <= r_q;
            pend_q.status <= sat_q ? nddi_pkg::STAT_SATURATED : nddi_pkg::STAT_OK;
            state_q       <= S_DONE;
          end else begin
            i_q     <= i_q - 1'b1;
            state_q <= S_E_CAP;
          end
        end
        S_E_CAP: begin
          c_i_q   <= c_rdata;
          state_q <= S_E_MUL;
        end
        S_E_MUL: begin
          if (mul_done) begin
            r_q     <= sum_sat;
            sat_q   <= sat_q || sum_ovf;
            state_q <= S_E_STEP;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_data_q <= pend_q;
            state_q    <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the Newton divided-difference interpolator.
// Holds a scoreboard class that predicts each result from the accepted inputs.
// Depends on nddi_pkg and newton_divided_difference_interp.
module tb_top;

  localparam int unsigned NODES = 16;
  localparam int unsigned FRAC  = 24;
  localparam longint      QMAX  = 64'sd2147483647;
  localparam longint      QMIN  = -64'sd2147483648;

  // Predicts the interpolator and checks its results in order.
  class nddi_scoreboard;
    longint          xs[NODES];
    longint          cs[NODES];
    int unsigned     held;
    bit              complete;
    bit              broken;
    logic [4:0]      count_reg;
    nddi_pkg::out_t  pending[$];
    int              errors;

    function new();
      held      = 0;
      complete  = 0;
      broken    = 0;
      count_reg = 5'd3;
      errors    = 0;
      foreach (xs[i]) begin
        xs[i] = 0;
        cs[i] = 0;
      end
    endfunction

    function int unsigned active_count();
      if (count_reg < 1) return 1;
      if (count_reg > NODES) return NODES;
      return count_reg;
    endfunction

    function longint div_floor(longint a, longint b);
      longint q;
      q = a / b;
      if ((a % b) != 0 && ((a < 0) != (b < 0))) q = q - 1;
      return q;
    endfunction

    function longint clip32(longint v, inout bit hit);
      if (v > QMAX) begin
        hit = 1;
        return QMAX;
      end
      if (v < QMIN) begin
        hit = 1;
        return QMIN;
      end
      return v;
    endfunction

    // Replaces the ordinates in place with divided differences.
    function logic [1:0] make_coefficients(int unsigned n);
      bit     hit;
      longint num;
      longint den;
      hit = 0;
      for (int k = 1; k < n; k++) begin
        for (int i = n - 1; i >= k; i--) begin
          num = cs[i] - cs[i-1];
          den = xs[i] - xs[i-k];
          if (den == 0) begin
            broken = 1;
            return nddi_pkg::STAT_DUPLICATE;
          end
          cs[i] = clip32(div_floor(num * (64'sd1 <<< FRAC), den), hit);
        end
      end
      return hit ? nddi_pkg::STAT_SATURATED : nddi_pkg::STAT_OK;
    endfunction

    // Notes an accepted input transaction and queues its expected result.
    function void note_input(nddi_pkg::in_t t);
      nddi_pkg::out_t res;
      int unsigned    n;
      longint         acc;
      bit             hit;
      res.value  = '0;
      res.status = nddi_pkg::STAT_OK;
      if (t.command == nddi_pkg::CMD_LOAD) begin
        n = active_count();
        if (complete || held >= n) begin
          held     = 0;
          complete = 0;
          broken   = 0;
        end
        xs[held] = longint'(t.node_x);
        cs[held] = longint'(t.node_y);
        held++;
        if (held == n) begin
          complete   = 1;
          res.status = make_coefficients(n);
        end
      end else if (!complete) begin
        res.status = nddi_pkg::STAT_NOT_READY;
      end else if (broken) begin
        res.status = nddi_pkg::STAT_DUPLICATE;
      end else begin
        hit = 0;
        acc = cs[held-1];
        for (int i = held - 2; i >= 0; i--) begin
          acc = clip32(div_floor(acc * (longint'(t.query_x) - xs[i]), 64'sd1 <<< FRAC)
                       + cs[i], hit);
        end
        res.value  = acc[31:0];
        res.status = hit ? nddi_pkg::STAT_SATURATED : nddi_pkg::STAT_OK;
      end
      pending = {pending, res};
    endfunction

    // Compares one result transaction with the oldest expectation.
    function void check_result(nddi_pkg::out_t r);
      nddi_pkg::out_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result value=%h status=%0d", $realtime, r.value, r.status);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (r.value !== e.value) begin
        $display("%0t: value mismatch, expected %h actual %h", $realtime, e.value, r.value);
        errors++;
      end
      if (r.status !== e.status) begin
        $display("%0t: status mismatch, expected %0d actual %0d", $realtime, e.status,
                 r.status);
        errors++;
      end
    endfunction
  endclass

  logic           clk_i = 1'b0;
  logic           rst_ni = 1'b0;
  logic           in_valid_i = 1'b0;
  logic           in_stall_o;
  nddi_pkg::in_t  in_data_i = '0;
  logic           out_valid_o;
  logic           out_stall_i = 1'b0;
  nddi_pkg::out_t out_data_o;
  logic           cfg_we_i = 1'b0;
  logic [4:0]     cfg_data_i = 5'd0;

  nddi_scoreboard sb = new();
  int  results_seen = 0;
  bit  stimulus_done = 0;
  bit  no_idle = 0;

  always #1 clk_i = ~clk_i;

  newton_divided_difference_interp u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i)
  );

  // Results are checked before the input of the same edge is noted.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(out_data_o);
        results_seen++;
      end
      if (in_valid_i && !in_stall_o) sb.note_input(in_data_i);
    end
  end

  // Idle length: mostly none or short, now and then long.
  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random stall, with one long hold-off while the sender keeps going.
  initial begin
    int  n;
    bit  held_off;
    held_off = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held_off && results_seen >= 40) begin
        held_off = 1;
        out_stall_i <= 1'b1;
        repeat (400) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        n = pick_gap();
        if (n > 0) begin
          out_stall_i <= 1'b1;
          repeat (n - 1) @(negedge clk_i);
        end else begin
          out_stall_i <= 1'b0;
        end
      end
    end
  end

  // Offers one transaction and holds it until accepted, then may idle a while.
  task automatic send_item(nddi_pkg::in_t t);
    int n;
    in_valid_i <= 1'b1;
    in_data_i  <= t;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
    n = pick_gap();
    if (n > 0) begin
      in_valid_i <= 1'b0;
      repeat (n - 1) @(negedge clk_i);
    end
  endtask

  task automatic load_node(logic signed [31:0] x, logic signed [31:0] y);
    nddi_pkg::in_t t;
    t = '0;
    t.command = nddi_pkg::CMD_LOAD;
    t.node_x  = x;
    t.node_y  = y;
    t.query_x = $urandom;
    send_item(t);
  endtask

  task automatic eval_at(logic signed [31:0] q);
    nddi_pkg::in_t t;
    t = '0;
    t.command = nddi_pkg::CMD_EVAL;
    t.node_x  = $urandom;
    t.node_y  = $urandom;
    t.query_x = q;
    send_item(t);
  endtask

  // Node count is written only once every result is back and the block is idle.
  task automatic write_count(logic [4:0] v);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_data_i <= v;
    sb.count_reg = v;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic signed [31:0] moderate();
    return int'($urandom_range(0, 32'h0800_0000)) - 32'sh0400_0000;
  endfunction

  // One set with random content, now and then with a duplicate abscissa, then a few evaluations.
  task automatic run_set(int unsigned n, ref int sent);
    logic signed [31:0] x;
    logic signed [31:0] step;
    logic signed [31:0] first;
    bit                 wild;
    wild  = ($urandom_range(0, 9) == 0);
    x     = wild ? $urandom : moderate();
    first = x;
    for (int i = 0; i < n; i++) begin
      if (wild) load_node($urandom, $urandom);
      else load_node(x, moderate());
      sent++;
      step = int'($urandom_range(32'h0040_0000, 32'h0180_0000));
      if ($urandom_range(0, 19) == 0) step = 0;
      if ($urandom_range(0, 1)) x = x + step;
      else x = x - step;
    end
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 7) == 0) eval_at($urandom);
      else eval_at(first + moderate());
      sent++;
    end
  endtask

  task automatic run_phase(logic [4:0] cnt, int items);
    int            sent;
    int unsigned   n;
    nddi_pkg::in_t t;
    write_count(cnt);
    n = (cnt < 1) ? 1 : ((cnt > NODES) ? NODES : cnt);
    sent = 0;
    no_idle = ($urandom_range(0, 3) == 0);
    while (sent < items) begin
      if ($urandom_range(0, 9) < 7) begin
        run_set(n, sent);
      end else begin
        t.command = 1'($urandom_range(0, 1));
        t.node_x  = $urandom;
        t.node_y  = $urandom;
        t.query_x = $urandom;
        send_item(t);
        sent++;
      end
    end
    no_idle = 0;
  endtask

  // Directed cases, then random phases over several node counts.
  initial begin
    logic [4:0] counts[12];
    counts = '{5'd3, 5'd1, 5'd0, 5'd2, 5'd4, 5'd16, 5'd31, 5'd5, 5'd17, 5'd2, 5'd6, 5'd3};
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Evaluate before any set, then a set at the field extremes.
    eval_at(32'sh0000_0000);
    load_node(32'sh8000_0000, 32'sh7fff_ffff);
    eval_at(32'sh7fff_ffff);
    load_node(32'sh7fff_ffff, 32'sh8000_0000);
    load_node(32'sh0000_0000, 32'sh0000_0000);
    eval_at(32'sh8000_0000);
    eval_at(32'sh7fff_ffff);
    eval_at(32'sh0100_0000);
    // Duplicate abscissa makes the set faulty.
    load_node(32'sh0100_0000, 32'sh0200_0000);
    load_node(32'sh0100_0000, 32'sh0300_0000);
    load_node(32'sh0200_0000, 32'sh0100_0000);
    eval_at(32'sh0180_0000);
    // Node count lowered during loading restarts the set.
    load_node(32'sh0100_0000, 32'sh0100_0000);
    load_node(32'sh0200_0000, 32'sh0400_0000);
    write_count(5'd2);
    load_node(32'shff00_0000, 32'sh7000_0000);
    load_node(32'sh0000_0001, 32'sh9000_0000);
    eval_at(32'sh7f00_0000);
    // Count changed after completion keeps the finished set.
    write_count(5'd4);
    eval_at(32'sh0000_8000);
    // Single node returns its ordinate.
    write_count(5'd1);
    load_node(32'sh1234_5678, 32'shdead_beef);
    eval_at(32'sh8765_4321);
    eval_at(32'sh0000_0000);

    foreach (counts[i]) run_phase(counts[i], (counts[i] == 5'd16) ? 60 : 100);

    in_valid_i <= 1'b0;
    @(negedge clk_i);
    stimulus_done = 1;
  end

  // End of run: drain, let the block settle, then report.
  initial begin
    wait (stimulus_done);
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #10000000;
    $display("simulation failed");
    $finish;
  end

endmodule
